@@ sv/hsh_pkg.sv @@
// Shared constants and types for the hashed symbol histogram.
package hsh_pkg;

  localparam int HASH_BITS = 8;
  localparam int HASH_SIZE = 1 << HASH_BITS;
  localparam int NAME_BITS = 6;
  localparam int NAME_LEN  = 1 << NAME_BITS;
  localparam int NAME_AW   = HASH_BITS + NAME_BITS;
  localparam int BUF_AW    = 6;
  localparam int STR_KEEP  = (1 << BUF_AW) - 1;
  localparam int CNT_W     = 32;

  localparam logic [6:0] HASH_BASE = 7'd101;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] RK_SAMPLE = 2'd0;
  localparam logic [1:0] RK_READ   = 2'd1;
  localparam logic [1:0] RK_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic       last_char;
    logic [7:0] bucket_index;
    logic [5:0] char_position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       bucket;
    logic [CNT_W-1:0] count;
    logic [7:0]       name_char;
  } out_word_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [HASH_BITS-1:0] wr_addr;
    logic [CNT_W-1:0]     wr_data;
    logic                 clear_all;
  } cnt_ctl_t;

  typedef struct packed {
    logic                 buf_we;
    logic [BUF_AW-1:0]    buf_addr;
    logic [7:0]           buf_data;
    logic [HASH_BITS-1:0] bucket;
    logic [BUF_AW-1:0]    len;
  } hash_out_t;

endpackage

@@ sv/hsh_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module hsh_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/hsh_count_store.sv @@
// Bucket counter memory with per-bucket valid bits for reset and clear.
module hsh_count_store
  import hsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_ctl_t         ctl,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]     mem [HASH_SIZE];
  logic [CNT_W-1:0]     mem_q_r;
  logic [HASH_SIZE-1:0] valid_r;
  logic                 vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    mem_q_r <= mem[ctl.rd_addr];
  end

  // A bucket whose valid bit is clear reads as zero, which gives both
  // the reset value and the clear operation without rewriting the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= valid_r[ctl.rd_addr];
      if (ctl.clear_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

@@ sv/hsh_hash.sv @@
// Running polynomial hash of the string in progress and its buffer write.
module hsh_hash
  import hsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic [7:0] char_code,
  input  logic      last_char,
  output hash_out_t hout
);

  logic [HASH_BITS-1:0] hash_r;
  logic [HASH_BITS-1:0] power_r;
  logic [BUF_AW-1:0]    idx_r;
  logic                 take;
  logic [HASH_BITS+7:0] prod;
  logic [HASH_BITS+6:0] pow_prod;
  logic [HASH_BITS-1:0] hash_nxt;
  logic [HASH_BITS-1:0] power_nxt;

  // Zero characters and characters past the first STR_KEEP kept ones are not hashed.
  assign take      = push && (char_code != 8'd0) && (32'(idx_r) < STR_KEEP);
  assign prod      = power_r * char_code;
  assign pow_prod  = power_r * HASH_BASE;
  assign hash_nxt  = hash_r + prod[HASH_BITS-1:0];
  assign power_nxt = pow_prod[HASH_BITS-1:0];

  always_comb begin
    hout.buf_we   = take;
    hout.buf_addr = idx_r;
    hout.buf_data = char_code;
    hout.bucket   = take ? hash_nxt : hash_r;
    hout.len      = take ? idx_r + BUF_AW'(1) : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      power_r <= HASH_BITS'(1);
      idx_r   <= '0;
    end else if (push && last_char) begin
      hash_r  <= '0;
      power_r <= HASH_BITS'(1);
      idx_r   <= '0;
    end else if (take) begin
      hash_r  <= hash_nxt;
      power_r <= power_nxt;
      idx_r   <= idx_r + BUF_AW'(1);
    end
  end

endmodule

@@ sv/hashed_symbol_histogram.sv @@
// Hashed symbol histogram top level: control sequencer and output register.
// A character that does not end its string leaves the sequencer idle, so such words
// stream at one per cycle. A final character has its bucket count read, then written
// back, and its name copied from the string buffer when its bucket was empty.
// A read fetches the bucket count and name character; a clear goes straight to its result.
// Synchronous reset clears the bucket valid bits at once; no clearing pass is needed.
module hashed_symbol_histogram
  import hsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_NAME,
    S_RD,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [HASH_BITS-1:0] bkt_r;
  logic [7:0]           idx_r;
  logic                 rd_ok_r;
  logic                 pos_ok_r;
  logic [BUF_AW-1:0]    len_r;
  logic [NAME_BITS:0]   sw_r;
  logic                 wr_en_r;
  logic [NAME_BITS-1:0] wr_k_r;
  out_word_t            res_r;
  out_word_t            out_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 push;
  logic                 out_free;
  hash_out_t            hout;
  cnt_ctl_t             cctl;
  logic [CNT_W-1:0]     cnt_old;
  logic [CNT_W-1:0]     cnt_new;
  logic [7:0]           buf_rdata;
  logic [7:0]           name_rdata;
  logic                 keep_char;
  logic [7:0]           name_wdata;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_data.operation == OP_PUSH);
  assign out_free = !out_valid_r || !out_stall;

  hsh_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .char_code (in_data.char_code),
    .last_char (in_data.last_char),
    .hout      (hout)
  );

  hsh_ram #(.AW(BUF_AW), .DW(8)) u_str_buf (
    .clk   (clk),
    .we    (hout.buf_we),
    .waddr (hout.buf_addr),
    .wdata (hout.buf_data),
    .raddr (BUF_AW'(sw_r)),
    .rdata (buf_rdata)
  );

  // Name characters past the kept string length, and the last name character, are written as zero.
  assign keep_char  = (32'(wr_k_r) < 32'(len_r)) && (32'(wr_k_r) < NAME_LEN - 1);
  assign name_wdata = keep_char ? buf_rdata : 8'd0;

  hsh_ram #(.AW(NAME_AW), .DW(8)) u_names (
    .clk   (clk),
    .we    (wr_en_r),
    .waddr ({bkt_r, wr_k_r}),
    .wdata (name_wdata),
    .raddr ({HASH_BITS'(in_data.bucket_index), NAME_BITS'(in_data.char_position)}),
    .rdata (name_rdata)
  );

  always_comb begin
    cctl.rd_addr   = (in_data.operation == OP_PUSH) ? hout.bucket
                                                    : HASH_BITS'(in_data.bucket_index);
    cctl.wr_en     = (state_r == S_CNT);
    cctl.wr_addr   = bkt_r;
    cctl.wr_data   = cnt_new;
    cctl.clear_all = accept && (in_data.operation == OP_CLEAR);
  end

  hsh_count_store u_counts (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cctl),
    .rd_data (cnt_old)
  );

  assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              OP_PUSH: begin
                if (in_data.last_char) begin
                  bkt_r   <= hout.bucket;
                  len_r   <= hout.len;
                  state_r <= S_CNT;
                end
              end
              OP_READ: begin
                bkt_r    <= HASH_BITS'(in_data.bucket_index);
                idx_r    <= in_data.bucket_index;
                rd_ok_r  <= (32'(in_data.bucket_index) < HASH_SIZE);
                pos_ok_r <= (32'(in_data.char_position) < NAME_LEN);
                state_r  <= S_RD;
              end
              OP_CLEAR: begin
                res_r   <= '{result_kind: RK_CLEAR, bucket: 8'd0, count: '0,
                             name_char: 8'd0};
                state_r <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_CNT: begin
          res_r <= '{result_kind: RK_SAMPLE, bucket: 8'(bkt_r), count: cnt_new,
                     name_char: 8'd0};
          if (cnt_old == '0) begin
            sw_r    <= '0;
            state_r <= S_NAME;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_NAME: begin
          // Buffer read issued at sw_r; its data is written in the following cycle.
          if (!sw_r[NAME_BITS]) begin
            wr_en_r <= 1'b1;
            wr_k_r  <= sw_r[NAME_BITS-1:0];
            sw_r    <= sw_r + (NAME_BITS+1)'(1);
          end else begin
            wr_en_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_RD: begin
          res_r <= '{result_kind: RK_READ, bucket: idx_r,
                     count: rd_ok_r ? cnt_old : '0,
                     name_char: (rd_ok_r && pos_ok_r) ? name_rdata : 8'd0};
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/hsh_checker.sv @@
// Port-level checker for the hashed symbol histogram, bound to the top level.
module hsh_checker
  import hsh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // A stalled result word stays up and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // A counted sample always leaves its bucket nonzero and carries no name character.
  a_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_SAMPLE) |->
      (out_data.count != '0) && (out_data.name_char == 8'd0))
    else $error("sample result with zero count or nonzero name character");

  a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_CLEAR) |->
      (out_data.bucket == 8'd0) && (out_data.count == '0) && (out_data.name_char == 8'd0))
    else $error("clear result with nonzero fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind hashed_symbol_histogram hsh_checker u_hsh_checker (.*);

@@ sim/hsh_checker.sv @@
// Checker for the hashed symbol histogram: predicts each result word and compares it.
module hsh_tb_checker
  import hsh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  output int                   fail_count,
  output int                   pending,
  output logic [HASH_SIZE-1:0] named_map
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CNT_W-1:0]     bucket_count [HASH_SIZE];
  logic [7:0]           bucket_name  [HASH_SIZE][NAME_LEN];
  logic [7:0]           string_chars [STR_KEEP+1];
  logic [HASH_BITS-1:0] run_hash;
  logic [HASH_BITS-1:0] run_power;
  logic [6:0]           kept;
  logic [HASH_SIZE-1:0] named_now;
  out_word_t            awaited_words [$];
  out_word_t            want_w;
  int                   errs;

  // Applies one accepted input word to the predicted state and queues its result.
  task automatic tally_word(input in_word_t w);
    out_word_t            r;
    logic [HASH_BITS-1:0] b;
    r = '0;
    case (w.operation)
      OP_PUSH: begin
        // Zero characters and characters past the kept length leave the hash alone.
        if (w.char_code != 8'd0 && kept < STR_KEEP) begin
          string_chars[kept] = w.char_code;
          run_hash  = HASH_BITS'(run_hash + run_power * w.char_code);
          run_power = HASH_BITS'(run_power * HASH_BASE);
          kept++;
        end
        if (w.last_char) begin
          b = run_hash;
          if (bucket_count[b] == '0) begin
            for (int k = 0; k < NAME_LEN; k++)
              bucket_name[b][k] = (k < kept && k < NAME_LEN - 1) ? string_chars[k] : 8'd0;
            named_now[b] = 1'b1;
          end
          if (bucket_count[b] != '1)
            bucket_count[b]++;
          r.result_kind = RK_SAMPLE;
          r.bucket      = 8'(b);
          r.count       = bucket_count[b];
          awaited_words.push_back(r);
          run_hash  = '0;
          run_power = HASH_BITS'(1);
          kept      = '0;
        end
      end
      OP_READ: begin
        r.result_kind = RK_READ;
        r.bucket      = w.bucket_index;
        r.count       = bucket_count[w.bucket_index];
        r.name_char   = bucket_name[w.bucket_index][w.char_position];
        awaited_words.push_back(r);
      end
      OP_CLEAR: begin
        for (int i = 0; i < HASH_SIZE; i++)
          bucket_count[i] = '0;
        r.result_kind = RK_CLEAR;
        awaited_words.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  function automatic bit field_ok(input string fname, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HASH_SIZE; i++) begin
        bucket_count[i] = '0;
        for (int k = 0; k < NAME_LEN; k++)
          bucket_name[i][k] = 8'd0;
      end
      for (int k = 0; k <= STR_KEEP; k++)
        string_chars[k] = 8'd0;
      run_hash  = '0;
      run_power = HASH_BITS'(1);
      kept      = '0;
      named_now = '0;
      awaited_words.delete();
      errs = 0;
    end else begin
      // Input first, so a result leaving on the same edge would still find its word.
      if (in_valid && !in_stall)
        tally_word(in_data);
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
          errs++;
        end else begin
          want_w = awaited_words.pop_front();
          if (!field_ok("result_kind", want_w.result_kind, out_data.result_kind)) errs++;
          if (!field_ok("bucket", want_w.bucket, out_data.bucket)) errs++;
          if (!field_ok("count", want_w.count, out_data.count)) errs++;
          if (!field_ok("name_char", want_w.name_char, out_data.name_char)) errs++;
        end
      end
    end
    fail_count <= errs;
    pending    <= awaited_words.size();
    named_map  <= named_now;
  end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the hashed symbol histogram: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hsh_pkg::*;

  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam int         RANDOM_WORDS = 850;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         CYCLE_LIMIT  = 500000;

  typedef logic [7:0] chars_t [$];

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  int                   fail_count;
  int                   pending;
  logic [HASH_SIZE-1:0] named_map;

  int     sent;
  int     cycles;
  bit     in_quiet;
  bit     out_quiet;
  chars_t pool [8];

  hashed_symbol_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsh_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .named_map  (named_map)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_word_t push_word(input logic [7:0] ch, input logic fin);
    in_word_t w;
    w.operation     = OP_PUSH;
    w.char_code     = ch;
    w.last_char     = fin;
    w.bucket_index  = 8'($urandom_range(0, 255));
    w.char_position = 6'($urandom_range(0, 63));
    return w;
  endfunction

  // Fields that the operation does not use carry random values.
  function automatic in_word_t plain_word(input logic [1:0] op);
    in_word_t w;
    w.operation     = op;
    w.char_code     = 8'($urandom_range(0, 255));
    w.last_char     = 1'($urandom_range(0, 1));
    w.bucket_index  = 8'($urandom_range(0, 255));
    w.char_position = 6'($urandom_range(0, 63));
    return w;
  endfunction

  function automatic in_word_t read_word(input logic [7:0] idx, input logic [5:0] pos);
    in_word_t w;
    w               = plain_word(OP_READ);
    w.bucket_index  = idx;
    w.char_position = pos;
    return w;
  endfunction

  // A bucket that already holds a name; only call when one exists.
  function automatic logic [7:0] named_bucket();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (!named_map[b])
      b++;
    return b;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back words.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (w.operation != OP_SPARE)
      sent++;
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    out_quiet = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int n;
      if ($urandom_range(0, 24) == 0)
        out_quiet = !out_quiet;
      n = out_quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    chars_t str;
    int     roll;
    int     len;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    in_quiet = 1'b0;
    sent     = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(push_word(8'h41, 1'b1));
    send_word(push_word(8'hFF, 1'b1));
    // A string of only a zero character is empty and lands in bucket 0.
    send_word(push_word(8'h00, 1'b1));
    send_word(push_word(8'hFF, 1'b0));
    send_word(push_word(8'h01, 1'b1));
    send_word(push_word(8'h10, 1'b0));
    send_word(push_word(8'h00, 1'b0));
    send_word(push_word(8'h20, 1'b1));
    send_word(push_word(8'h33, 1'b0));
    send_word(push_word(8'h00, 1'b1));
    send_word(read_word(8'h41, 6'd0));
    send_word(read_word(8'h41, 6'd1));
    send_word(read_word(8'hFF, 6'd63));
    send_word(read_word(8'h00, 6'd0));
    // Read and clear in the middle of a string must not disturb its hash.
    send_word(push_word(8'h55, 1'b0));
    send_word(read_word(8'h41, 6'd0));
    send_word(plain_word(OP_CLEAR));
    send_word(push_word(8'h66, 1'b1));
    send_word(plain_word(OP_SPARE));
    send_word(push_word(8'h41, 1'b1));
    send_word(read_word(8'h41, 6'd0));

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 19) == 0)
        in_quiet = !in_quiet;
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        // Reusing earlier strings drives counts above one and hits named buckets.
        if ($urandom_range(0, 9) < 4 && pool[$urandom_range(0, 7)].size() != 0) begin
          str = pool[$urandom_range(0, 7)];
          while (str.size() == 0)
            str = pool[$urandom_range(0, 7)];
        end else begin
          str.delete();
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            str.push_back(($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
          pool[$urandom_range(0, 7)] = str;
        end
        for (int i = 0; i < str.size(); i++) begin
          if (named_map != '0 && $urandom_range(0, 19) == 0)
            send_word(read_word(named_bucket(), 6'($urandom_range(0, 63))));
          send_word(push_word(str[i], i == str.size() - 1));
        end
      end else if (roll < 93) begin
        if (named_map != '0)
          send_word(read_word(named_bucket(), 6'($urandom_range(0, 63))));
      end else if (roll < 95) begin
        send_word(plain_word(OP_CLEAR));
      end else begin
        send_word(plain_word(OP_SPARE));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hsh_pkg.sv
sv/hsh_ram.sv
sv/hsh_count_store.sv
sv/hsh_hash.sv
sv/hashed_symbol_histogram.sv
sv/hsh_checker.sv
sim/hsh_checker.sv
sim/testbench.sv
